@@ rtl/i2cm_pkg.sv @@
// Package for the I2C master bit engine: command codes, phase codes and the
// queue entry type shared by the front end, the back end and the top level.
// No dependencies.
`timescale 1ns / 1ps

package i2cm_pkg;

	typedef enum logic [2:0] {
		FN_START = 3'd0,
		FN_STOP  = 3'd1,
		FN_WRITE = 3'd2,
		FN_READ  = 3'd3,
		FN_SACK  = 3'd4,
		FN_RACK  = 3'd5
	} func_t;

	// Position inside one written bit: data setup, clock high, clock low.
	typedef enum logic [1:0] {
		WB_DATA = 2'd0,
		WB_HIGH = 2'd1,
		WB_LOW  = 2'd2
	} wbit_t;

	localparam int unsigned BYTE_BITS = 8;
	localparam int unsigned PH_W      = 5;
	localparam logic [PH_W-1:0] LAST_WRITE = PH_W'(3 * BYTE_BITS - 1);
	localparam logic [PH_W-1:0] LAST_READ  = PH_W'(2 * BYTE_BITS);
	localparam logic [PH_W-1:0] LAST_SHORT = PH_W'(2);
	localparam logic [BYTE_BITS-1:0] MSB_MASK = 8'h80;

	// One classified tick waiting in the queue between front and back.
	typedef struct packed {
		logic            cmd_ok;    // command offered and its code is known
		func_t           func;
		logic [PH_W-1:0] last_ph;   // last phase index of the offered command
		logic [7:0]      wr_data;
		logic            ack_bit;
		logic            sda_line;
	} tick_t;

endpackage

@@ rtl/i2c_master_bit_engine.sv @@
// I2C master bit engine: one accepted request is one bus phase tick, one result per tick.
// An accepted request waits in the front-end queue; once popped, its result is registered.
// Throughput: one request per cycle while out_stall is low; the engine advances one phase
// per popped tick and the two-entry queue plus the output register decouple the sides.
// Reset (arst_n, asynchronous): engine idle, SCL and SDA released high, ack level one,
// shift registers zero, queue and output register empty. Uses i2cm_pkg, front and back.
`timescale 1ns / 1ps

module i2c_master_bit_engine import i2cm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// Input channel: one bus tick per request.
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       cmd_valid,
	input  logic [2:0] func,
	input  logic [7:0] wr_data,
	input  logic       ack_bit,
	input  logic       sda_line,
	// Output channel: bus levels and status after each tick.
	output logic       out_valid,
	input  logic       out_stall,
	output logic       scl,
	output logic       sda_drive,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] rd_data,
	output logic       ack_level
);

	// The front end decodes each request as it arrives: whether a known command
	// is offered and how many phases it runs. Decoded ticks wait in a short queue.
	tick_t q_head;
	logic  q_valid;
	logic  q_pop;

	i2cm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd_valid (cmd_valid),
		.func      (func),
		.wr_data   (wr_data),
		.ack_bit   (ack_bit),
		.sda_line  (sda_line),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop)
	);

	// The back end owns the bus state. It takes one tick from the queue whenever
	// its output register is empty or being drained, starts a command only when
	// idle (commands offered while busy are dropped) and runs one phase per tick while a command runs.
	i2cm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.scl       (scl),
		.sda_drive (sda_drive),
		.busy_res  (busy_res),
		.done_res  (done_res),
		.rd_data   (rd_data),
		.ack_level (ack_level)
	);

endmodule

@@ rtl/i2cm_front.sv @@
// Front end of the I2C master bit engine: accepts tick requests, classifies
// the offered command and holds them in a two-entry queue. Uses i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_front import i2cm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       cmd_valid,
	input  logic [2:0] func,
	input  logic [7:0] wr_data,
	input  logic       ack_bit,
	input  logic       sda_line,
	output logic       q_valid,
	output tick_t      q_head,
	input  logic       q_pop
);

	tick_t      slot_q [2];
	logic [1:0] count_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic       push;
	tick_t      entry;

	always_comb begin
		entry.cmd_ok   = cmd_valid && (func inside {[FN_START:FN_RACK]});
		entry.func     = func_t'(func);
		entry.wr_data  = wr_data;
		entry.ack_bit  = ack_bit;
		entry.sda_line = sda_line;
		case (func)
			FN_WRITE: entry.last_ph = LAST_WRITE;
			FN_READ:  entry.last_ph = LAST_READ;
			default:  entry.last_ph = LAST_SHORT;
		endcase
	end

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign q_head   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2) else $error("queue count out of range");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> count_q != 2'd0) else $error("pop from empty queue");
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with count");

endmodule

@@ rtl/i2cm_back.sv @@
// Back end of the I2C master bit engine: runs one bus phase per queued tick
// while a command is active and presents the bus levels and status in an
// output register. Uses i2cm_pkg and is fed by i2cm_front.
`timescale 1ns / 1ps

module i2cm_back import i2cm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  tick_t      q_head,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       scl,
	output logic       sda_drive,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] rd_data,
	output logic       ack_level
);

	logic            active_q;
	func_t           func_q;
	logic [PH_W-1:0] phase_q;
	logic [PH_W-1:0] last_q;
	wbit_t           wbit_q;
	logic [7:0]      tx_q;
	logic [7:0]      rx_q;
	logic            ack_q;
	logic            scl_q;
	logic            sda_q;
	logic            out_valid_q;

	logic            take;
	logic            act;
	func_t           fn;
	logic [PH_W-1:0] ph;
	logic [PH_W-1:0] last;
	wbit_t           wb;
	logic [7:0]      tx_cur;
	logic            done;
	logic            active_d;
	logic [PH_W-1:0] phase_d;
	wbit_t           wbit_d;
	logic [7:0]      tx_d;
	logic [7:0]      rx_d;
	logic            ack_d;
	logic            scl_d;
	logic            sda_d;

	assign q_pop = q_valid && (!out_valid_q || !out_stall);

	always_comb begin
		take   = !active_q && q_head.cmd_ok;
		act    = take || active_q;
		fn     = take ? q_head.func : func_q;
		ph     = take ? '0 : phase_q;
		last   = take ? q_head.last_ph : last_q;
		wb     = take ? WB_DATA : wbit_q;
		tx_cur = (take && q_head.func == FN_WRITE) ? q_head.wr_data : tx_q;
		tx_d   = tx_cur;
		rx_d   = rx_q;
		ack_d  = ack_q;
		scl_d  = scl_q;
		sda_d  = sda_q;
		done   = 1'b0;
		active_d = active_q;
		phase_d  = phase_q;
		wbit_d   = wbit_q;
		if (act) begin
			case (fn)
				FN_START: begin
					if (ph == '0) begin
						scl_d = 1'b1;
						sda_d = 1'b1;
					end else if (ph == PH_W'(1)) begin
						sda_d = 1'b0;
					end else begin
						scl_d = 1'b0;
					end
				end
				FN_STOP: begin
					if (ph == '0) begin
						sda_d = 1'b0;
					end else if (ph == PH_W'(1)) begin
						scl_d = 1'b1;
					end else begin
						sda_d = 1'b1;
					end
				end
				FN_WRITE: begin
					case (wb)
						WB_DATA: sda_d = |(tx_cur & MSB_MASK);
						WB_HIGH: scl_d = 1'b1;
						default: begin
							scl_d = 1'b0;
							tx_d  = {tx_cur[6:0], 1'b0};
						end
					endcase
				end
				FN_READ: begin
					if (ph == '0) begin
						sda_d = 1'b1;
					end else if (ph[0]) begin
						scl_d = 1'b1;
						rx_d  = {rx_q[6:0], q_head.sda_line};
					end else begin
						scl_d = 1'b0;
					end
				end
				FN_SACK: begin
					if (ph == '0) begin
						sda_d = q_head.ack_bit;
					end else if (ph == PH_W'(1)) begin
						scl_d = 1'b1;
					end else begin
						scl_d = 1'b0;
					end
				end
				default: begin
					if (ph == '0) begin
						sda_d = 1'b1;
					end else if (ph == PH_W'(1)) begin
						scl_d = 1'b1;
						ack_d = q_head.sda_line;
					end else begin
						scl_d = 1'b0;
					end
				end
			endcase
			if (ph == last) begin
				done     = 1'b1;
				active_d = 1'b0;
				phase_d  = '0;
				wbit_d   = WB_DATA;
			end else begin
				active_d = 1'b1;
				phase_d  = ph + PH_W'(1);
				wbit_d   = (wb == WB_LOW) ? WB_DATA : wbit_t'(wb + 2'd1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			func_q      <= FN_START;
			phase_q     <= '0;
			last_q      <= LAST_SHORT;
			wbit_q      <= WB_DATA;
			tx_q        <= '0;
			rx_q        <= '0;
			ack_q       <= 1'b1;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				active_q <= active_d;
				phase_q  <= phase_d;
				wbit_q   <= wbit_d;
				tx_q     <= tx_d;
				rx_q     <= rx_d;
				ack_q    <= ack_d;
				scl_q    <= scl_d;
				sda_q    <= sda_d;
				if (take) begin
					func_q <= q_head.func;
					last_q <= q_head.last_ph;
				end
			end
			if (q_pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			scl       <= scl_d;
			sda_drive <= sda_d;
			busy_res  <= active_d;
			done_res  <= done;
			rd_data   <= rx_d;
			ack_level <= ack_d;
		end
	end

	assign out_valid = out_valid_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_res |-> !busy_res) else $error("done while still busy");
	a_phase_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> phase_q <= last_q) else $error("phase past command end");
	a_idle_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> phase_q == '0 && wbit_q == WB_DATA)
		else $error("idle engine holds a stale phase");
	a_pop_shows: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> out_valid_q) else $error("popped tick produced no result");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the I2C master bit engine: drives bus phase ticks and
// predicts SCL, SDA, status, read byte and ack level for every tick in the testbench.
// Depends on i2cm_pkg and i2c_master_bit_engine.
`timescale 1ns / 1ps

module testbench;
	import i2cm_pkg::*;

	// The run is bounded by a cycle counter. About 2000 ticks arrive at roughly 88% on
	// each side.
	localparam int unsigned CYCLE_LIMIT = 200000;
	// Neither side idles while the cycle count is inside this window.
	localparam int unsigned QUIET_LO    = 1000;
	localparam int unsigned QUIET_HI    = 1600;
	localparam int unsigned IDLE_PCT    = 12;
	localparam int unsigned RAND_TICKS  = 2000;
	// Extra wait after the last predicted result, to catch stray results.
	localparam int unsigned DRAIN_WAIT  = 8;

	// One bus phase tick as offered on the request channel.
	typedef struct packed {
		logic       cmd_v;
		logic [2:0] fn;
		logic [7:0] wd;
		logic       ackb;
		logic       line;
	} bus_tick_t;

	// Bus levels and status after one tick.
	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] rd;
		logic       ack;
	} bus_levels_t;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic       cmd_valid = 1'b0;
	logic [2:0] func      = '0;
	logic [7:0] wr_data   = '0;
	logic       ack_bit   = 1'b0;
	logic       sda_line  = 1'b1;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       scl;
	logic       sda_drive;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rd_data;
	logic       ack_level;

	bus_tick_t   phase_ticks[$];     // ticks still to be offered
	bus_levels_t pending_levels[$];  // predicted results not yet seen
	int unsigned n_ticks    = 0;
	int unsigned n_accepted = 0;
	int unsigned errors     = 0;
	int unsigned cyc        = 0;
	bus_tick_t   next_tick;

	// Shadow copy of the engine state, updated once per accepted request.
	logic [4:0] ph_cnt;
	func_t      cur_func;
	logic       running;
	logic [7:0] tx_sr;
	logic [7:0] rx_sr;
	logic       ack_q;
	logic       scl_q;
	logic       sda_q;

	i2c_master_bit_engine uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd_valid (cmd_valid),
		.func      (func),
		.wr_data   (wr_data),
		.ack_bit   (ack_bit),
		.sda_line  (sda_line),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.scl       (scl),
		.sda_drive (sda_drive),
		.busy_res  (busy_res),
		.done_res  (done_res),
		.rd_data   (rd_data),
		.ack_level (ack_level)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Random hold-off shared by both sides, suppressed inside the quiet window.
	function bit hold_off();
		if (cyc >= QUIET_LO && cyc < QUIET_HI)
			return 1'b0;
		return $urandom_range(0, 99) < IDLE_PCT;
	endfunction

	// Number of ticks that a command occupies the engine.
	function int unsigned cmd_ticks(input func_t f);
		case (f)
			FN_WRITE: return 3 * BYTE_BITS;
			FN_READ:  return 2 * BYTE_BITS + 1;
			default:  return 3;
		endcase
	endfunction

	// Advances the shadow engine by one tick and queues the bus levels it leads to.
	function void step_bus_engine(input bus_tick_t t);
		bus_levels_t r;
		int unsigned k;
		r.done = 1'b0;
		// A command is only taken while idle and only with a known code.
		if (!running && t.cmd_v && t.fn <= FN_RACK) begin
			running  = 1'b1;
			cur_func = func_t'(t.fn);
			ph_cnt   = '0;
			if (cur_func == FN_WRITE)
				tx_sr = t.wd;
		end
		if (running) begin
			case (cur_func)
				FN_START: begin
					if (ph_cnt == 0) begin
						scl_q = 1'b1;
						sda_q = 1'b1;
					end else if (ph_cnt == 1)
						sda_q = 1'b0;
					else
						scl_q = 1'b0;
				end
				FN_STOP: begin
					if (ph_cnt == 0)
						sda_q = 1'b0;
					else if (ph_cnt == 1)
						scl_q = 1'b1;
					else
						sda_q = 1'b1;
				end
				FN_WRITE: begin
					// Each bit: put the MSB on SDA, raise SCL, lower SCL and shift.
					k = ph_cnt % 3;
					if (k == 0)
						sda_q = tx_sr[7];
					else if (k == 1)
						scl_q = 1'b1;
					else begin
						scl_q = 1'b0;
						tx_sr = {tx_sr[6:0], 1'b0};
					end
				end
				FN_READ: begin
					// Release SDA first, then sample on every rising SCL.
					if (ph_cnt == 0)
						sda_q = 1'b1;
					else if (ph_cnt[0]) begin
						scl_q = 1'b1;
						rx_sr = {rx_sr[6:0], t.line};
					end else
						scl_q = 1'b0;
				end
				FN_SACK: begin
					if (ph_cnt == 0)
						sda_q = t.ackb;
					else if (ph_cnt == 1)
						scl_q = 1'b1;
					else
						scl_q = 1'b0;
				end
				default: begin
					if (ph_cnt == 0)
						sda_q = 1'b1;
					else if (ph_cnt == 1) begin
						scl_q = 1'b1;
						ack_q = t.line;
					end else
						scl_q = 1'b0;
				end
			endcase
			if (ph_cnt + 1 >= cmd_ticks(cur_func)) begin
				running = 1'b0;
				ph_cnt  = '0;
				r.done  = 1'b1;
			end else
				ph_cnt = ph_cnt + 1'b1;
		end
		r.scl  = scl_q;
		r.sda  = sda_q;
		r.busy = running;
		r.rd   = rx_sr;
		r.ack  = ack_q;
		pending_levels.push_back(r);
	endfunction

	task push_tick(input logic cv, input logic [2:0] fn, input logic [7:0] wd,
			input logic ab, input logic ln);
		phase_ticks.push_back('{cmd_v: cv, fn: fn, wd: wd, ackb: ab, line: ln});
		n_ticks++;
	endtask

	// Offers a command on an idle engine and fills the rest of its ticks with noise that
	// the busy engine must ignore. The pattern gives the SDA levels seen at the sample
	// points: MSB first for a read, bit 0 for a receive ack.
	task issue_cmd(input func_t f, input logic [7:0] wd, input logic ab,
			input logic [7:0] pattern);
		int unsigned p;
		logic ln;
		for (p = 0; p < cmd_ticks(f); p++) begin
			ln = 1'($urandom_range(0, 1));
			if (f == FN_READ && p[0])
				ln = pattern[7 - (p - 1) / 2];
			else if (f == FN_RACK && p == 1)
				ln = pattern[0];
			if (p == 0)
				push_tick(1'b1, f, wd, ab, ln);
			else
				push_tick(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), ln);
		end
	endtask

	// A command with random byte, ack level and sample pattern.
	task issue_rand(input func_t f);
		issue_cmd(f, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			8'($urandom_range(0, 255)));
	endtask

	// A tick on an idle engine that must not start anything: either no command is
	// offered or the code is one of the two unused ones.
	task idle_noise();
		logic cv;
		cv = 1'($urandom_range(0, 1));
		push_tick(cv, cv ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 7)),
			8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endtask

	// A well-formed transfer: start, one to three bytes each with its ack, an optional
	// read byte answered by the master, and a stop.
	task gen_transfer();
		int unsigned nbytes;
		nbytes = $urandom_range(1, 3);
		issue_rand(FN_START);
		repeat (nbytes) begin
			issue_rand(FN_WRITE);
			issue_rand(FN_RACK);
		end
		if ($urandom_range(0, 1)) begin
			issue_rand(FN_READ);
			issue_rand(FN_SACK);
		end
		issue_rand(FN_STOP);
	endtask

	// Request driver. The payload only moves on once the current request has been taken,
	// so valid stays high through any stall and the prediction runs on the taken tick.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			cmd_valid <= 1'b0;
			func      <= '0;
			wr_data   <= '0;
			ack_bit   <= 1'b0;
			sda_line  <= 1'b1;
		end else begin
			if (in_valid && !in_stall) begin
				step_bus_engine('{cmd_v: cmd_valid, fn: func, wd: wr_data,
					ackb: ack_bit, line: sda_line});
				n_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (phase_ticks.size() > 0 && !hold_off()) begin
					next_tick = phase_ticks.pop_front();
					in_valid  <= 1'b1;
					cmd_valid <= next_tick.cmd_v;
					func      <= next_tick.fn;
					wr_data   <= next_tick.wd;
					ack_bit   <= next_tick.ackb;
					sda_line  <= next_tick.line;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Result monitor. Every taken result is compared field by field against the oldest
	// prediction, and the stall for the next edge is drawn at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else begin
			if (out_valid && !out_stall) begin
				if (pending_levels.size() == 0) begin
					$error("result with no request outstanding: scl %0d sda %0d", scl,
						sda_drive);
					errors++;
				end else begin
					bus_levels_t w;
					w = pending_levels.pop_front();
					if (scl !== w.scl) begin
						$error("scl expected %0d got %0d", w.scl, scl);
						errors++;
					end
					if (sda_drive !== w.sda) begin
						$error("sda_drive expected %0d got %0d", w.sda, sda_drive);
						errors++;
					end
					if (busy_res !== w.busy) begin
						$error("busy_res expected %0d got %0d", w.busy, busy_res);
						errors++;
					end
					if (done_res !== w.done) begin
						$error("done_res expected %0d got %0d", w.done, done_res);
						errors++;
					end
					if (rd_data !== w.rd) begin
						$error("rd_data expected %02h got %02h", w.rd, rd_data);
						errors++;
					end
					if (ack_level !== w.ack) begin
						$error("ack_level expected %0d got %0d", w.ack, ack_level);
						errors++;
					end
				end
			end
			out_stall <= hold_off();
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cyc++;
		if (cyc >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		// Shadow state as after reset: bus released, ack level one, shift registers zero.
		ph_cnt   = '0;
		cur_func = FN_START;
		running  = 1'b0;
		tx_sr    = '0;
		rx_sr    = '0;
		ack_q    = 1'b1;
		scl_q    = 1'b1;
		sda_q    = 1'b1;

		// Directed part. The idle ticks include both unused codes, and every command's
		// tail carries noise that a busy engine must ignore. Writes cover all-ones,
		// all-zeros and the mixed byte A5. The acks come back as both ack and nack, and
		// the reads sample all ones, all zeros and a mixed byte.
		push_tick(1'b0, FN_WRITE, 8'h00, 1'b0, 1'b0);
		push_tick(1'b1, 3'd6, 8'hFF, 1'b1, 1'b1);
		push_tick(1'b1, 3'd7, 8'h00, 1'b0, 1'b0);
		issue_cmd(FN_START, 8'h00, 1'b0, 8'h00);
		issue_cmd(FN_WRITE, 8'hFF, 1'b1, 8'h00);
		issue_cmd(FN_RACK, 8'h00, 1'b0, 8'h00);
		issue_cmd(FN_WRITE, 8'h00, 1'b0, 8'h00);
		issue_cmd(FN_RACK, 8'h00, 1'b0, 8'h01);
		issue_cmd(FN_WRITE, 8'hA5, 1'b0, 8'h00);
		issue_cmd(FN_READ, 8'h00, 1'b0, 8'hFF);
		issue_cmd(FN_SACK, 8'h00, 1'b0, 8'h00);
		issue_cmd(FN_READ, 8'h00, 1'b1, 8'h00);
		issue_cmd(FN_SACK, 8'hFF, 1'b1, 8'h00);
		issue_cmd(FN_READ, 8'h00, 1'b0, 8'h5A);
		issue_cmd(FN_STOP, 8'h00, 1'b0, 8'h00);

		// Random part: mostly complete transfers with random content, mixed with single
		// commands in any order and some idle noise.
		while (n_ticks < RAND_TICKS) begin
			int unsigned roll;
			roll = $urandom_range(0, 99);
			if (roll < 10)
				repeat ($urandom_range(1, 4)) idle_noise();
			else if (roll < 30)
				issue_rand(func_t'($urandom_range(0, 5)));
			else
				gen_transfer();
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every tick has been taken and every predicted result has arrived,
		// then watch a little longer for stray results.
		while (n_accepted < n_ticks || pending_levels.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
